@@ design/psaf_pkg.sv @@
package psaf_pkg;

    // actions
    localparam logic [2:0] ACT_CHECK     = 3'd0;
    localparam logic [2:0] ACT_SET_PEER  = 3'd1;
    localparam logic [2:0] ACT_CLR_PEER  = 3'd2;
    localparam logic [2:0] ACT_SET_SVC   = 3'd3;
    localparam logic [2:0] ACT_CLASSIFY  = 3'd4;
    localparam logic [2:0] ACT_CLR_ALL   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DENIED    = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_NOSPACE   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;

    // peer classes
    localparam logic [2:0] CLS_OBSERVED      = 3'd0;
    localparam logic [2:0] CLS_CHALLENGED    = 3'd1;
    localparam logic [2:0] CLS_AUTHENTICATED = 3'd2;
    localparam logic [2:0] CLS_TRUSTED       = 3'd3;
    localparam logic [2:0] CLS_BLOCKED       = 3'd4;
    localparam logic [2:0] CLS_CONFLICTED    = 3'd5;

    // peer policy
    localparam logic [1:0] POL_DEFAULT = 2'd0;
    localparam logic [1:0] POL_TRUSTED = 2'd1;
    localparam logic [1:0] POL_BLOCKED = 2'd2;

    // service rule codes
    localparam logic [1:0] SRULE_ALLOW = 2'd0;
    localparam logic [1:0] SRULE_DENY  = 2'd1;
    localparam logic [1:0] SRULE_CLEAR = 2'd2;
    localparam logic [1:0] SRULE_BAD   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_REQUIRE_TRUST     = 2'd0;
    localparam logic [1:0] CFG_ALLOW_BROADCAST   = 2'd1;
    localparam logic [1:0] CFG_PROTECTED_SERVICE = 2'd2;

    localparam int SERVICE_BITS = 16;

    typedef struct packed {
        logic set;
        logic drop;
        logic wipe;
        logic flag;
    } t_cell_cmd;

    typedef struct packed {
        logic any_hit;
        logic any_free;
        logic hit_flag;
    } t_row_stat;

endpackage

@@ design/peer_service_access_filter.sv @@
// the result strobe is registered from the execute state that follows the start transfer
// busy holds off a new item while one executes; table cells match in the accept cycle,
// the decision and table write happen in the following cycle
// reset clears both tables, the state, the config registers and the strobe at once; no sweep needed
// results cannot be stalled by the receiver
module peer_service_access_filter #(
    parameter int PEER_ENTRIES = 16,
    parameter int RULE_ENTRIES = 16,
    parameter int NODE_ID_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_node_id,
    input  logic [15:0] i_service,
    input  logic        i_broadcast,
    input  logic        i_peer_rule,
    input  logic [1:0]  i_service_rule,
    input  logic        i_peer_conflicted,
    input  logic        i_session_ready,
    input  logic        i_handshake_pending,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [2:0]  o_peer_class,
    output logic [1:0]  o_peer_policy
);
    import psaf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;

    logic                    r_require_trust;
    logic                    r_allow_broadcast;
    logic [SERVICE_BITS-1:0] r_protected_service;

    logic [2:0]              r_action;
    logic [NODE_ID_BITS-1:0] r_key;
    logic [SERVICE_BITS-1:0] r_service;
    logic                    r_broadcast;
    logic                    r_peer_rule;
    logic [1:0]              r_service_rule;
    logic                    r_conflicted;
    logic                    r_ready;
    logic                    r_pending;

    logic       r_done;
    logic [2:0] r_status;
    logic [2:0] r_peer_class;
    logic [1:0] r_peer_policy;

    logic [2:0] n_status;
    logic [2:0] n_peer_class;
    logic [1:0] n_peer_policy;

    logic                    accept;
    logic                    exec;
    logic [NODE_ID_BITS-1:0] peer_key;
    logic [SERVICE_BITS-1:0] rule_key;
    logic                    key_zero;
    logic                    svc_ok;
    t_cell_cmd               peer_cmd;
    t_cell_cmd               rule_cmd;
    t_row_stat               peer_stat;
    t_row_stat               rule_stat;

    assign accept      = start && !busy;
    assign exec        = (r_state == S_EXEC);
    assign busy        = exec;
    assign o_cfg_ready = 1'b1;

    // cells match against the live item at accept, then against the held item for the write
    assign peer_key = exec ? r_key     : i_node_id[NODE_ID_BITS-1:0];
    assign rule_key = exec ? r_service : i_service;

    assign key_zero = (r_key == '0);
    assign svc_ok   = (r_service != r_protected_service) && (r_service_rule != SRULE_BAD);

    always_comb begin
        peer_cmd      = '0;
        rule_cmd      = '0;
        peer_cmd.flag = r_peer_rule;
        rule_cmd.flag = (r_service_rule == SRULE_DENY);
        if (exec) begin
            peer_cmd.set  = (r_action == ACT_SET_PEER) && !key_zero;
            peer_cmd.drop = (r_action == ACT_CLR_PEER) && !key_zero;
            peer_cmd.wipe = (r_action == ACT_CLR_ALL);
            rule_cmd.set  = (r_action == ACT_SET_SVC) && svc_ok
                            && (r_service_rule != SRULE_CLEAR);
            rule_cmd.drop = (r_action == ACT_SET_SVC) && svc_ok
                            && (r_service_rule == SRULE_CLEAR);
            rule_cmd.wipe = (r_action == ACT_CLR_ALL);
        end
    end

    psaf_row #(.ENTRIES(PEER_ENTRIES), .KEY_BITS(NODE_ID_BITS)) u_peer_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (peer_key),
        .i_cmd   (peer_cmd),
        .o_stat  (peer_stat)
    );

    psaf_row #(.ENTRIES(RULE_ENTRIES), .KEY_BITS(SERVICE_BITS)) u_rule_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (rule_key),
        .i_cmd   (rule_cmd),
        .o_stat  (rule_stat)
    );

    always_comb begin
        n_status      = ST_OK;
        n_peer_class  = CLS_OBSERVED;
        n_peer_policy = POL_DEFAULT;
        unique case (r_action)
            ACT_CHECK: begin
                if (!r_broadcast && peer_stat.hit_flag) begin
                    n_status = ST_DENIED;
                end else if (!r_broadcast && r_require_trust && !peer_stat.any_hit) begin
                    n_status = ST_DENIED;
                end else if (r_broadcast && !r_allow_broadcast) begin
                    n_status = ST_DENIED;
                end else if (rule_stat.hit_flag) begin
                    n_status = ST_DENIED;
                end
            end
            ACT_SET_PEER: begin
                if (key_zero) begin
                    n_status = ST_INVALID;
                end else if (!peer_stat.any_hit && !peer_stat.any_free) begin
                    n_status = ST_NOSPACE;
                end
            end
            ACT_CLR_PEER: begin
                if (key_zero) begin
                    n_status = ST_INVALID;
                end else if (!peer_stat.any_hit) begin
                    n_status = ST_NOTFOUND;
                end
            end
            ACT_SET_SVC: begin
                if (!svc_ok) begin
                    n_status = ST_INVALID;
                end else if (r_service_rule == SRULE_CLEAR) begin
                    if (!rule_stat.any_hit) begin
                        n_status = ST_NOTFOUND;
                    end
                end else if (!rule_stat.any_hit && !rule_stat.any_free) begin
                    n_status = ST_NOSPACE;
                end
            end
            ACT_CLASSIFY: begin
                if (peer_stat.any_hit) begin
                    n_peer_policy = peer_stat.hit_flag ? POL_BLOCKED : POL_TRUSTED;
                end
                if (peer_stat.hit_flag) begin
                    n_peer_class = CLS_BLOCKED;
                end else if (r_conflicted) begin
                    n_peer_class = CLS_CONFLICTED;
                end else if (!r_ready) begin
                    n_peer_class = r_pending ? CLS_CHALLENGED : CLS_OBSERVED;
                end else begin
                    n_peer_class = peer_stat.any_hit ? CLS_TRUSTED : CLS_AUTHENTICATED;
                end
            end
            ACT_CLR_ALL: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (accept) begin
            r_state <= S_EXEC;
        end else if (exec) begin
            r_state <= S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action       <= i_action;
            r_key          <= i_node_id[NODE_ID_BITS-1:0];
            r_service      <= i_service;
            r_broadcast    <= i_broadcast;
            r_peer_rule    <= i_peer_rule;
            r_service_rule <= i_service_rule;
            r_conflicted   <= i_peer_conflicted;
            r_ready        <= i_session_ready;
            r_pending      <= i_handshake_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_trust     <= 1'b0;
            r_allow_broadcast   <= 1'b1;
            r_protected_service <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REQUIRE_TRUST:     r_require_trust     <= i_cfg_data[0];
                CFG_ALLOW_BROADCAST:   r_allow_broadcast   <= i_cfg_data[0];
                CFG_PROTECTED_SERVICE: r_protected_service <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status      <= n_status;
            r_peer_class  <= n_peer_class;
            r_peer_policy <= n_peer_policy;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_peer_class  = r_peer_class;
    assign o_peer_policy = r_peer_policy;

endmodule

@@ design/psaf_cell.sv @@
module psaf_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  psaf_pkg::t_cell_cmd i_cmd,
    input  logic                i_sel,
    input  logic                i_free_in,
    output logic                o_free_out,
    output logic                o_hit,
    output logic                o_first,
    output logic                o_flag
);
    import psaf_pkg::*;

    logic                r_used;
    logic [KEY_BITS-1:0] r_key;
    logic                r_flag;
    logic                r_hit;
    logic                r_first;

    // a free slot somewhere before or at this cell
    assign o_free_out = i_free_in | ~r_used;
    assign o_hit      = r_hit;
    assign o_first    = r_first;
    assign o_flag     = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.wipe) begin
            r_used <= 1'b0;
        end else if (i_sel && i_cmd.set) begin
            r_used <= 1'b1;
        end else if (i_sel && i_cmd.drop) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && i_cmd.set && !i_cmd.wipe) begin
            r_key  <= i_key;
            r_flag <= i_cmd.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= r_used && (r_key == i_key);
        r_first <= ~r_used & ~i_free_in;
    end

endmodule

@@ design/psaf_row.sv @@
module psaf_row #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  psaf_pkg::t_cell_cmd i_cmd,
    output psaf_pkg::t_row_stat o_stat
);
    import psaf_pkg::*;

    logic [ENTRIES:0]   free_chain;
    logic [ENTRIES-1:0] hit;
    logic [ENTRIES-1:0] first;
    logic [ENTRIES-1:0] flag;
    logic [ENTRIES-1:0] sel;
    logic               any_hit;

    assign free_chain[0] = 1'b0;
    assign any_hit       = |hit;

    // update in place on a match, else take the first free slot
    assign sel = (i_cmd.set && !any_hit) ? first : hit;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        psaf_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (i_key),
            .i_cmd      (i_cmd),
            .i_sel      (sel[g]),
            .i_free_in  (free_chain[g]),
            .o_free_out (free_chain[g+1]),
            .o_hit      (hit[g]),
            .o_first    (first[g]),
            .o_flag     (flag[g])
        );
    end

    assign o_stat.any_hit  = any_hit;
    assign o_stat.any_free = |first;
    assign o_stat.hit_flag = |(hit & flag);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import psaf_pkg::*;

    localparam int PEER_SLOTS = 16;
    localparam int RULE_SLOTS = 16;
    localparam int ID_BITS    = 64;
    localparam int POOL_SIZE  = 24;

    // action codes the block must reject
    localparam logic [2:0] ACT_UNDEF_6 = 3'd6;
    localparam logic [2:0] ACT_UNDEF_7 = 3'd7;

    localparam logic LO = 1'b0;
    localparam logic HI = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] node_id;
        logic [15:0] service;
        logic        broadcast;
        logic        peer_rule;
        logic [1:0]  service_rule;
        logic        conflicted;
        logic        ready;
        logic        pending;
    } t_filter_req;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] peer_class;
        logic [1:0] peer_policy;
    } t_filter_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_filter_req on_wire = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_cfg_ready;
    logic        o_done;
    logic [2:0]  o_status;
    logic [2:0]  o_peer_class;
    logic [1:0]  o_peer_policy;

    peer_service_access_filter #(
        .PEER_ENTRIES(PEER_SLOTS),
        .RULE_ENTRIES(RULE_SLOTS),
        .NODE_ID_BITS(ID_BITS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (on_wire.action),
        .i_node_id          (on_wire.node_id),
        .i_service          (on_wire.service),
        .i_broadcast        (on_wire.broadcast),
        .i_peer_rule        (on_wire.peer_rule),
        .i_service_rule     (on_wire.service_rule),
        .i_peer_conflicted  (on_wire.conflicted),
        .i_session_ready    (on_wire.ready),
        .i_handshake_pending(on_wire.pending),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_peer_class       (o_peer_class),
        .o_peer_policy      (o_peer_policy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter state mirror
    logic        want_trust = 1'b0;
    logic        bcast_ok = 1'b1;
    logic [15:0] guarded_svc = '0;
    bit          peer_used [PEER_SLOTS];
    logic [63:0] peer_key [PEER_SLOTS];
    logic        peer_blk [PEER_SLOTS];
    bit          rule_used [RULE_SLOTS];
    logic [15:0] rule_svc [RULE_SLOTS];
    logic        rule_deny [RULE_SLOTS];

    t_filter_req  pending_reqs[$];
    t_filter_resp expected_resps[$];
    t_filter_resp predicted;
    t_filter_resp oldest;
    t_filter_req  next_req;
    int           fail_count = 0;
    logic         item_taken = 1'b0;
    int           idle_left = 0;
    bit           no_idle = 1'b0;
    logic [63:0]  id_pool [POOL_SIZE];
    logic [15:0]  svc_pool [POOL_SIZE];

    function automatic int peer_slot(input logic [63:0] id);
        for (int k = 0; k < PEER_SLOTS; k++)
            if (peer_used[k] && peer_key[k] == id) return k;
        return -1;
    endfunction

    function automatic int free_peer_slot();
        for (int k = 0; k < PEER_SLOTS; k++)
            if (!peer_used[k]) return k;
        return -1;
    endfunction

    function automatic int rule_slot(input logic [15:0] svc);
        for (int k = 0; k < RULE_SLOTS; k++)
            if (rule_used[k] && rule_svc[k] == svc) return k;
        return -1;
    endfunction

    function automatic int free_rule_slot();
        for (int k = 0; k < RULE_SLOTS; k++)
            if (!rule_used[k]) return k;
        return -1;
    endfunction

    task automatic predict_filter(input t_filter_req rq, output t_filter_resp rs);
        int p;
        int r;
        rs = '{ST_OK, CLS_OBSERVED, POL_DEFAULT};
        case (rq.action)
            ACT_CHECK: begin
                // broadcasts skip the peer lookup
                if (!rq.broadcast) begin
                    p = peer_slot(rq.node_id);
                    if (p >= 0 && peer_blk[p]) rs.status = ST_DENIED;
                    else if (want_trust && p < 0) rs.status = ST_DENIED;
                end
                if (rs.status == ST_OK) begin
                    if (rq.broadcast && !bcast_ok) begin
                        rs.status = ST_DENIED;
                    end else begin
                        r = rule_slot(rq.service);
                        if (r >= 0 && rule_deny[r]) rs.status = ST_DENIED;
                    end
                end
            end
            ACT_SET_PEER: begin
                if (rq.node_id == '0) begin
                    rs.status = ST_INVALID;
                end else begin
                    p = peer_slot(rq.node_id);
                    if (p < 0) p = free_peer_slot();
                    if (p < 0) begin
                        rs.status = ST_NOSPACE;
                    end else begin
                        peer_used[p] = 1'b1;
                        peer_key[p]  = rq.node_id;
                        peer_blk[p]  = rq.peer_rule;
                    end
                end
            end
            ACT_CLR_PEER: begin
                if (rq.node_id == '0) begin
                    rs.status = ST_INVALID;
                end else begin
                    p = peer_slot(rq.node_id);
                    if (p < 0) rs.status = ST_NOTFOUND;
                    else peer_used[p] = 1'b0;
                end
            end
            ACT_SET_SVC: begin
                if (rq.service == guarded_svc || rq.service_rule == SRULE_BAD) begin
                    rs.status = ST_INVALID;
                end else begin
                    r = rule_slot(rq.service);
                    if (rq.service_rule == SRULE_CLEAR) begin
                        if (r < 0) rs.status = ST_NOTFOUND;
                        else rule_used[r] = 1'b0;
                    end else begin
                        if (r < 0) r = free_rule_slot();
                        if (r < 0) begin
                            rs.status = ST_NOSPACE;
                        end else begin
                            rule_used[r] = 1'b1;
                            rule_svc[r]  = rq.service;
                            rule_deny[r] = (rq.service_rule == SRULE_DENY);
                        end
                    end
                end
            end
            ACT_CLASSIFY: begin
                p = peer_slot(rq.node_id);
                if (p >= 0) rs.peer_policy = peer_blk[p] ? POL_BLOCKED : POL_TRUSTED;
                if (p >= 0 && peer_blk[p]) rs.peer_class = CLS_BLOCKED;
                else if (rq.conflicted) rs.peer_class = CLS_CONFLICTED;
                else if (!rq.ready)
                    rs.peer_class = rq.pending ? CLS_CHALLENGED : CLS_OBSERVED;
                else rs.peer_class = (p >= 0) ? CLS_TRUSTED : CLS_AUTHENTICATED;
            end
            ACT_CLR_ALL: begin
                for (int k = 0; k < PEER_SLOTS; k++) peer_used[k] = 1'b0;
                for (int k = 0; k < RULE_SLOTS; k++) rule_used[k] = 1'b0;
            end
            default: rs.status = ST_INVALID;
        endcase
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 45) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 95) return $urandom_range(8, 4);
        return $urandom_range(40, 12);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || item_taken)) begin
            if ($urandom_range(39) == 0) no_idle <= !no_idle;
            if (idle_left > 0) begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                on_wire <= next_req;
                start <= 1'b1;
                idle_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REQUIRE_TRUST:     want_trust = i_cfg_data[0];
                    CFG_ALLOW_BROADCAST:   bcast_ok = i_cfg_data[0];
                    CFG_PROTECTED_SERVICE: guarded_svc = i_cfg_data;
                    default: ;
                endcase
            end
            // older result is retired before the new transfer is predicted
            if (o_done) begin
                if (expected_resps.size() == 0) begin
                    $error("result with no pending expectation");
                    fail_count++;
                end else begin
                    oldest = expected_resps.pop_front();
                    if (o_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, o_status);
                        fail_count++;
                    end
                    if (o_peer_class !== oldest.peer_class) begin
                        $error("peer_class: expected %0d, actual %0d",
                               oldest.peer_class, o_peer_class);
                        fail_count++;
                    end
                    if (o_peer_policy !== oldest.peer_policy) begin
                        $error("peer_policy: expected %0d, actual %0d",
                               oldest.peer_policy, o_peer_policy);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                predict_filter(on_wire, predicted);
                expected_resps.push_back(predicted);
            end
        end
    end

    function automatic t_filter_req mk_req(input logic [2:0] act, input logic [63:0] id,
                                           input logic [15:0] svc, input logic bc,
                                           input logic prule, input logic [1:0] srule,
                                           input logic conf, input logic rdy,
                                           input logic pend);
        t_filter_req rq;
        rq = '{act, id, svc, bc, prule, srule, conf, rdy, pend};
        return rq;
    endfunction

    function automatic logic [63:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4) return '0;
        if (roll < 86) return id_pool[$urandom_range(POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] pick_svc();
        if ($urandom_range(99) < 82) return svc_pool[$urandom_range(POOL_SIZE - 1)];
        return 16'($urandom_range(65535));
    endfunction

    function automatic t_filter_req rand_req();
        t_filter_req rq;
        int roll;
        rq.node_id      = pick_id();
        rq.service      = pick_svc();
        rq.broadcast    = ($urandom_range(3) == 0);
        rq.peer_rule    = 1'($urandom_range(1));
        rq.conflicted   = ($urandom_range(4) == 0);
        rq.ready        = 1'($urandom_range(1));
        rq.pending      = 1'($urandom_range(1));
        roll = $urandom_range(19);
        if (roll < 8) rq.service_rule = SRULE_ALLOW;
        else if (roll < 15) rq.service_rule = SRULE_DENY;
        else if (roll < 19) rq.service_rule = SRULE_CLEAR;
        else rq.service_rule = SRULE_BAD;
        roll = $urandom_range(99);
        if (roll < 36) rq.action = ACT_CHECK;
        else if (roll < 56) rq.action = ACT_SET_PEER;
        else if (roll < 62) rq.action = ACT_CLR_PEER;
        else if (roll < 80) rq.action = ACT_SET_SVC;
        else if (roll < 96) rq.action = ACT_CLASSIFY;
        else if (roll < 97) rq.action = ACT_CLR_ALL;
        else rq.action = $urandom_range(1) ? ACT_UNDEF_6 : ACT_UNDEF_7;
        return rq;
    endfunction

    // sender holds off until every expected result is back
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_resps.size() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic trust, input logic bcast, input logic [15:0] prot,
                             input int n_reqs, input bit fill_first);
        wait_quiet();
        cfg_write(CFG_REQUIRE_TRUST, {15'd0, trust});
        cfg_write(CFG_ALLOW_BROADCAST, {15'd0, bcast});
        cfg_write(CFG_PROTECTED_SERVICE, prot);
        if (fill_first) begin
            // overrun both tables to reach the no-space answers
            repeat (18)
                pending_reqs.push_back(mk_req(ACT_SET_PEER, {$urandom, $urandom} | 64'd1,
                                              '0, 1'b0, 1'($urandom_range(1)),
                                              SRULE_ALLOW, 1'b0, 1'b0, 1'b0));
            repeat (18)
                pending_reqs.push_back(mk_req(ACT_SET_SVC, '0,
                                              16'($urandom_range(65535)), 1'b0, 1'b0,
                                              $urandom_range(1) ? SRULE_DENY
                                                                : SRULE_ALLOW,
                                              1'b0, 1'b0, 1'b0));
        end
        repeat (n_reqs) pending_reqs.push_back(rand_req());
    endtask

    initial begin
        id_pool[0]  = '1;
        id_pool[1]  = 64'd1;
        id_pool[2]  = 64'h8000_0000_0000_0000;
        svc_pool[0] = 16'h0000;
        svc_pool[1] = 16'hFFFF;
        for (int k = 3; k < POOL_SIZE; k++) id_pool[k] = {$urandom, $urandom} | 64'd2;
        for (int k = 2; k < POOL_SIZE; k++) svc_pool[k] = 16'($urandom_range(65535));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed checks with the registers at their reset values
        pending_reqs.push_back(mk_req(ACT_CHECK, '0, 16'h0000, HI, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_PEER, '0, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CLR_PEER, '0, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CLR_PEER, 64'd5, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_PEER, '1, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_PEER, 64'd1, '0, LO, HI, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_PEER, 64'd1, '0, LO, HI, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CHECK, 64'd1, 16'd7, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CHECK, 64'd1, 16'd7, HI, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CHECK, '1, 16'hFFFF, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CLASSIFY, '1, '0, LO, LO, SRULE_ALLOW, LO, HI, LO));
        pending_reqs.push_back(mk_req(ACT_CLASSIFY, 64'd1, '0, LO, LO, SRULE_ALLOW, HI, HI, HI));
        pending_reqs.push_back(mk_req(ACT_CLASSIFY, 64'd9, '0, LO, LO, SRULE_ALLOW, HI, HI, LO));
        pending_reqs.push_back(mk_req(ACT_CLASSIFY, 64'd9, '0, LO, LO, SRULE_ALLOW, LO, LO, HI));
        pending_reqs.push_back(mk_req(ACT_CLASSIFY, 64'd9, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CLASSIFY, 64'd9, '0, LO, LO, SRULE_ALLOW, LO, HI, LO));
        pending_reqs.push_back(mk_req(ACT_SET_SVC, '0, 16'h0000, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_SVC, '0, 16'hFFFF, LO, LO, SRULE_DENY, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CHECK, '1, 16'hFFFF, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_SVC, '0, 16'd7, LO, LO, SRULE_BAD, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_SVC, '0, 16'd8, LO, LO, SRULE_CLEAR, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_SET_SVC, '0, 16'hFFFF, LO, LO, SRULE_CLEAR, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_UNDEF_6, '1, '1, HI, HI, SRULE_BAD, HI, HI, HI));
        pending_reqs.push_back(mk_req(ACT_UNDEF_7, 64'd3, 16'd3, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CLR_ALL, '0, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));
        pending_reqs.push_back(mk_req(ACT_CLR_PEER, '1, '0, LO, LO, SRULE_ALLOW, LO, LO, LO));

        run_phase(1'b1, 1'b0, 16'hFFFF, 95, 1'b1);
        run_phase(1'b0, 1'b0, svc_pool[$urandom_range(POOL_SIZE - 1)], 125, 1'b0);
        run_phase(1'b1, 1'b1, 16'h0000, 125, 1'b0);
        run_phase(1'b0, 1'b1, 16'($urandom_range(65535)), 125, 1'b0);
        run_phase(1'b1, 1'b0, svc_pool[$urandom_range(POOL_SIZE - 1)], 125, 1'b0);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("peer_service_access_filter test passed");
        end else begin
            $display("peer_service_access_filter test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("peer_service_access_filter test failed");
        $finish;
    end

endmodule
